// ===== hw/rtl/wbd_pkg.sv =====
// ============================================================================
// Windowed burst delay package
// Shared types, register indexes and field widths of the burst delay block.
// ============================================================================
package wbd_pkg;

    localparam int ID_W    = 32;
    localparam int SEQ_W   = 16;
    localparam int TRIG_W  = 6;
    localparam int DRAW_W  = 7;
    localparam int CNT_W   = 12;
    localparam int LEN_W   = 6;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 48;
    localparam int ADDR_W  = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = 12'd4095;

    localparam logic [1:0] REG_FIRST_END    = 2'd0;
    localparam logic [1:0] REG_SECOND_START = 2'd1;
    localparam logic [1:0] REG_SECOND_END   = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] first_end;
        logic [CNT_W-1:0] second_start;
        logic [CNT_W-1:0] second_end;
    } t_cfg;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [SEQ_W-1:0] seq;
    } t_entry;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FILL,
        PH_RELEASE
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_LAST
    } t_state;

endpackage

// ===== hw/rtl/windowed_burst_delay_impairment.sv =====
// ============================================================================
// Windowed burst delay impairment
// Holds bursts of packets inside packet-count windows and releases them in
// order ahead of the next packet.
// ============================================================================
// Packets enter on the s_ stream, one word per packet; verdicts leave on the
// m_ stream, one word per accepted packet, with tuser set on a word released
// from hold and tlast on the final word caused by an input packet.
// A passed packet is accepted in the idle state and its word is loaded into
// the output word register from the last state, so a new packet is taken
// only after the word of the previous one is loaded. A packet that is stored
// in the hold memory gives no word and leaves the sequencer idle. The packet
// after a full burst drains the hold memory entry by entry, through a read
// state and a load state of the registered read port, then emits itself.
// s_tready is low while a release or an output word is being sequenced.
// When the receiver stalls, the output word register holds its word and the
// sequencer waits; a new packet is taken only once the last word is loaded.
// Reset clears the packet counter, the burst state and the output valid and
// sets the window registers to 500, 1500 and 2500. The hold memory is not
// cleared; it is always written before it is read.
// ============================================================================
module windowed_burst_delay_impairment
    import wbd_pkg::*;
#(
    parameter int HOLD_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // [31:0] packet_id, [47:32] sequence_number, [53:48] trigger_draw,
    // [60:54] burst_draw, [63:61] zero
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [31:0] accepted_id, [47:32] accepted_sequence
    output logic [OUT_W-1:0]  m_tdata,
    // [0] was_delayed
    output logic              m_tuser,
    output logic              m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    t_cfg          r_cfg;
    logic          cfg_write;
    logic [1:0]    reg_idx;
    t_entry        in_entry;
    t_entry        out_entry;
    t_entry        wdata;
    t_entry        rdata;
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_end    <= CNT_W'(500);
            r_cfg.second_start <= CNT_W'(1500);
            r_cfg.second_end   <= CNT_W'(2500);
        end else if (cfg_write) begin
            case (reg_idx)
                REG_FIRST_END:    r_cfg.first_end    <= pwdata[CNT_W-1:0];
                REG_SECOND_START: r_cfg.second_start <= pwdata[CNT_W-1:0];
                REG_SECOND_END:   r_cfg.second_end   <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FIRST_END:    prdata = 32'(r_cfg.first_end);
            REG_SECOND_START: prdata = 32'(r_cfg.second_start);
            REG_SECOND_END:   prdata = 32'(r_cfg.second_end);
            default:          prdata = '0;
        endcase
    end

    assign in_entry.id  = s_tdata[31:0];
    assign in_entry.seq = s_tdata[47:32];
    assign wdata        = in_entry;

    wbd_seq #(
        .HOLD_DEPTH (HOLD_DEPTH),
        .AW         (AW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (s_tvalid),
        .o_in_ready    (s_tready),
        .i_in_entry    (in_entry),
        .i_trig        (s_tdata[53:48]),
        .i_draw        (s_tdata[60:54]),
        .o_we          (we),
        .o_waddr       (waddr),
        .o_raddr       (raddr),
        .i_rdata       (rdata),
        .o_out_valid   (m_tvalid),
        .i_out_ready   (m_tready),
        .o_out_entry   (out_entry),
        .o_out_delayed (m_tuser),
        .o_out_last    (m_tlast)
    );

    wbd_hold_mem #(
        .DEPTH (HOLD_DEPTH),
        .AW    (AW)
    ) u_hold_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign m_tdata = {out_entry.seq, out_entry.id};

endmodule

// ===== hw/rtl/wbd_hold_mem.sv =====
// ============================================================================
// Hold memory
// One write port and one registered read port for held packet entries.
// ============================================================================
module wbd_hold_mem
    import wbd_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/wbd_seq.sv =====
// ============================================================================
// Burst delay sequencer
// Packet counter, window check, hold fill and release sequencing, and the
// output word register.
// ============================================================================
module wbd_seq
    import wbd_pkg::*;
#(
    parameter int HOLD_DEPTH = 64,
    parameter int AW         = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_entry            i_in_entry,
    input  logic [TRIG_W-1:0] i_trig,
    input  logic [DRAW_W-1:0] i_draw,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [AW-1:0]     o_raddr,
    input  t_entry            i_rdata,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_entry            o_out_entry,
    output logic              o_out_delayed,
    output logic              o_out_last
);

    localparam int BURST_CAP = ((HOLD_DEPTH - 1) < 63) ? (HOLD_DEPTH - 1) : 63;

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [LEN_W-1:0] r_fill, n_fill;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_idx, n_idx;
    t_entry           r_cur;
    logic             r_out_valid;
    t_entry           r_out_entry;
    logic             r_out_delayed;
    logic             r_out_last;

    logic             accept;
    logic             out_free;
    logic             in_window;
    logic             trigger;
    logic [LEN_W-1:0] clamp_len;
    logic [LEN_W-1:0] fill_pos;
    logic [LEN_W-1:0] fill_len;
    logic             filling;
    logic             load_held;
    logic             load_cur;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_count = (r_count < COUNT_MAX) ? r_count + 1'b1 : r_count;
        in_window = (n_count < i_cfg.first_end) ||
                    ((n_count > i_cfg.second_start) && (n_count < i_cfg.second_end));
        trigger = (r_phase == PH_IDLE) && in_window && (i_trig == '0);
        if (i_draw > DRAW_W'(BURST_CAP)) begin
            clamp_len = LEN_W'(BURST_CAP);
        end else if (i_draw == '0) begin
            clamp_len = LEN_W'(1);
        end else begin
            clamp_len = i_draw[LEN_W-1:0];
        end
        fill_pos = trigger ? '0 : r_fill;
        fill_len = trigger ? clamp_len : r_len;
        filling  = trigger || (r_phase == PH_FILL);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_fill  = r_fill;
        n_len   = r_len;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (filling) begin
                        n_len  = fill_len;
                        n_fill = fill_pos + 1'b1;
                        n_phase = (fill_pos + 1'b1 >= fill_len) ? PH_RELEASE : PH_FILL;
                    end else if (r_phase == PH_RELEASE) begin
                        n_phase = PH_IDLE;
                        n_idx   = '0;
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_LAST;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    if (r_idx == r_len - 1'b1) begin
                        n_state = ST_LAST;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_READ;
                    end
                end
            end
            ST_LAST: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_in_ready = 1'b0;
        load_held  = 1'b0;
        load_cur   = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_READ: ;
            ST_LOAD: load_held = out_free;
            ST_LAST: load_cur  = out_free;
            default: ;
        endcase
    end

    assign o_we    = accept && filling;
    assign o_waddr = AW'(fill_pos);
    assign o_raddr = AW'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_fill      <= '0;
            r_len       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_idx   <= n_idx;
            if (accept) begin
                r_count <= n_count;
            end
            if (load_held || load_cur) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur <= i_in_entry;
        end
        if (load_held) begin
            r_out_entry   <= i_rdata;
            r_out_delayed <= 1'b1;
            r_out_last    <= 1'b0;
        end else if (load_cur) begin
            r_out_entry   <= r_cur;
            r_out_delayed <= 1'b0;
            r_out_last    <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_entry   = r_out_entry;
    assign o_out_delayed = r_out_delayed;
    assign o_out_last    = r_out_last;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Burst delay impairment testbench
// Streams packets into the block under random sender bursts and receiver
// stalls, predicts every verdict word from its own copy of the window, burst
// and hold state, and checks each output word field by field. The run walks
// through several window settings and the edges of narrow windows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import wbd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [SEQ_W-1:0] seq;
        logic             delayed;
        logic             last;
    } t_verdict;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tuser;
    logic              m_tlast;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    logic [IN_W-1:0] pkt_q[$];
    t_verdict        verdict_q[$];
    int              pushed = 0;
    int              mismatches = 0;

    t_cfg            cfg;
    t_phase          ph;
    logic [CNT_W-1:0] pkt_count;
    logic [LEN_W-1:0] fill_pos;
    logic [LEN_W-1:0] burst_len;
    t_entry          hold_mem[64];

    int run_left = 0;
    int gap_left = 0;
    int rx_cycle = 0;
    int stall_left = 0;
    bit rx_steady = 1'b0;
    int idle_cycles = 0;

    windowed_burst_delay_impairment DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void note_mismatch(string what, logic [47:0] want, logic [47:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch %0s: expected %h, got %h", what, want, got);
        end
    endfunction

    function automatic void predict_packet(logic [IN_W-1:0] w);
        logic [ID_W-1:0]   id;
        logic [SEQ_W-1:0]  seq;
        logic [TRIG_W-1:0] trig;
        logic [DRAW_W-1:0] draw;
        logic              win_open;
        t_verdict          v;
        id   = w[31:0];
        seq  = w[47:32];
        trig = w[53:48];
        draw = w[60:54];
        if (pkt_count < COUNT_MAX) begin
            pkt_count++;
        end
        win_open = (pkt_count < cfg.first_end) ||
                   (pkt_count > cfg.second_start && pkt_count < cfg.second_end);
        if (ph == PH_IDLE && win_open && trig == '0) begin
            if (draw > 7'd63) begin
                burst_len = 6'd63;
            end else if (draw == 7'd0) begin
                burst_len = 6'd1;
            end else begin
                burst_len = draw[5:0];
            end
            fill_pos = '0;
            ph = PH_FILL;
        end
        if (ph == PH_FILL) begin
            hold_mem[fill_pos] = '{id: id, seq: seq};
            fill_pos++;
            if (fill_pos >= burst_len) begin
                ph = PH_RELEASE;
            end
            return;
        end
        if (ph == PH_RELEASE) begin
            for (int i = 0; i < burst_len; i++) begin
                v = '{id: hold_mem[i].id, seq: hold_mem[i].seq, delayed: 1'b1, last: 1'b0};
                verdict_q.push_back(v);
            end
            ph = PH_IDLE;
        end
        v = '{id: id, seq: seq, delayed: 1'b0, last: 1'b1};
        verdict_q.push_back(v);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            cfg = '{first_end: 12'd500, second_start: 12'd1500, second_end: 12'd2500};
            ph = PH_IDLE;
            pkt_count = '0;
            fill_pos = '0;
            burst_len = '0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                predict_packet(s_tdata);
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pkt_q.size() == 0) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= pkt_q.pop_front();
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    run_left = $urandom_range(0, 15);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 150 == 0) begin
                rx_steady = ($urandom_range(0, 2) == 0);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                note_mismatch("unexpected word", '0, m_tdata);
            end else begin
                want = verdict_q.pop_front();
                if (m_tdata[31:0] !== want.id) begin
                    note_mismatch("accepted_id", 48'(want.id), 48'(m_tdata[31:0]));
                end
                if (m_tdata[47:32] !== want.seq) begin
                    note_mismatch("accepted_sequence", 48'(want.seq), 48'(m_tdata[47:32]));
                end
                if (m_tuser !== want.delayed) begin
                    note_mismatch("was_delayed", 48'(want.delayed), 48'(m_tuser));
                end
                if (m_tlast !== want.last) begin
                    note_mismatch("last_of_run", 48'(want.last), 48'(m_tlast));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [TRIG_W-1:0] rand_trig();
        return ($urandom_range(0, 2) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
    endfunction

    function automatic logic [DRAW_W-1:0] rand_draw();
        return ($urandom_range(0, 9) == 0) ? 7'($urandom_range(9, 127))
                                           : 7'($urandom_range(0, 8));
    endfunction

    task automatic add_packet(logic [ID_W-1:0] id, logic [SEQ_W-1:0] seq,
                              logic [TRIG_W-1:0] trig, logic [DRAW_W-1:0] draw);
        pkt_q.push_back({3'b000, draw, trig, seq, id});
        pushed++;
    endtask

    // A trigger word, the words that fill the burst, and the word that releases it.
    task automatic add_burst(logic [DRAW_W-1:0] draw, bit zero_trig);
        int len;
        len = (draw > 63) ? 63 : ((draw == 0) ? 1 : int'(draw));
        add_packet($urandom, 16'($urandom_range(0, 65535)), 6'd0, draw);
        for (int i = 0; i < len; i++) begin
            add_packet($urandom, 16'($urandom_range(0, 65535)),
                       zero_trig ? 6'd0 : rand_trig(), rand_draw());
        end
    endtask

    task automatic run_random(int count);
        int goal;
        goal = pushed + count;
        while (pushed < goal) begin
            if ($urandom_range(0, 9) < 7) begin
                add_burst(7'($urandom_range(0, 8)), 1'b0);
            end else begin
                add_packet($urandom, 16'($urandom_range(0, 65535)), rand_trig(), rand_draw());
            end
        end
    endtask

    task automatic wait_drained();
        while (pkt_q.size() != 0 || s_tvalid || verdict_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CNT_W-1:0] val);
        logic [31:0] rd;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {20'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_FIRST_END: begin
                cfg.first_end = val;
            end
            REG_SECOND_START: begin
                cfg.second_start = val;
            end
            REG_SECOND_END: begin
                cfg.second_end = val;
            end
            default: begin
            end
        endcase
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd[CNT_W-1:0] !== val) begin
            note_mismatch("register readback", 48'(val), 48'(rd[CNT_W-1:0]));
        end
        @(negedge i_clk);
    endtask

    initial begin
        logic [CNT_W-1:0] base;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_packet(32'h0000_0000, 16'h0000, 6'd1, 7'd0);
        add_packet(32'hFFFF_FFFF, 16'hFFFF, 6'd63, 7'd127);
        add_packet($urandom, 16'($urandom_range(0, 65535)), 6'd49, 7'd64);
        add_burst(7'd0, 1'b1);
        add_burst(7'd1, 1'b0);
        add_burst(7'd2, 1'b1);
        add_burst(7'd3, 1'b0);
        add_burst(7'd127, 1'b0);
        wait_drained();

        write_reg(REG_FIRST_END, 12'd0);
        write_reg(REG_SECOND_START, 12'd0);
        write_reg(REG_SECOND_END, 12'd4095);
        run_random(15);
        wait_drained();

        write_reg(REG_FIRST_END, 12'd4095);
        write_reg(REG_SECOND_START, 12'd4095);
        write_reg(REG_SECOND_END, 12'd0);
        run_random(10);
        wait_drained();

        // Narrow windows just ahead of the current count to hit both edges of each.
        base = pkt_count;
        write_reg(REG_FIRST_END, base + 12'd3);
        write_reg(REG_SECOND_START, base + 12'd5);
        write_reg(REG_SECOND_END, base + 12'd8);
        repeat (10) add_packet($urandom, 16'($urandom_range(0, 65535)), 6'd0, 7'd1);
        wait_drained();
        repeat (20) @(negedge i_clk);

        if (verdict_q.size() != 0) begin
            note_mismatch("words never seen", 48'(verdict_q.size()), '0);
        end
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
